// ===== design/hds_pkg.sv =====
// Shared types and constants for the H-bridge direction sequencer.
`timescale 1ns / 1ps

package hds_pkg;

    localparam int NUM_MOTORS  = 16;
    localparam int MOTOR_SEL_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [14:0] DEADBAND_RST    = 15'd328;
    localparam logic [15:0] OFF_REFRESH_RST = 16'd50;
    localparam logic [14:0] DUTY_MAX        = 15'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND    = 1'b0,
        CFG_OFF_REFRESH = 1'b1
    } t_cfg_reg;

    typedef logic [MOTOR_SEL_W-1:0] t_motor_sel;

    typedef struct packed {
        logic [3:0]         motor_index;
        logic signed [15:0] drive_command;
        logic               enable_request;
        logic [15:0]        refresh_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  motor_echo;
        logic        enable_line;
        logic        low_side_one;
        logic        low_side_two;
        logic [14:0] high_one_duty;
        logic [14:0] high_two_duty;
        logic [15:0] period_ms;
        logic        fet_delay_taken;
    } t_out_item;

    // direction: 0 = high direction, 1 = low direction
    typedef struct packed {
        logic enabled;
        logic direction;
        logic first_cmd;
    } t_motor_flags;

    localparam t_motor_flags FLAGS_RST = '{enabled: 1'b0, direction: 1'b0, first_cmd: 1'b1};

endpackage

// ===== design/hds_flag_bank.sv =====
// Per-motor flag storage: enabled, direction and first-command flags.
`timescale 1ns / 1ps

module hds_flag_bank (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hds_pkg::t_motor_sel   i_rd_sel,
    output hds_pkg::t_motor_flags o_rd_flags,
    input  logic                  i_wr_en,
    input  hds_pkg::t_motor_sel   i_wr_sel,
    input  hds_pkg::t_motor_flags i_wr_flags
);

    hds_pkg::t_motor_flags r_flags [hds_pkg::NUM_MOTORS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hds_pkg::NUM_MOTORS; i++) begin
                r_flags[i] <= hds_pkg::FLAGS_RST;
            end
        end else if (i_wr_en) begin
            r_flags[i_wr_sel] <= i_wr_flags;
        end
    end

    assign o_rd_flags = r_flags[i_rd_sel];

endmodule

// ===== design/hds_step.sv =====
// Combinational per-transaction sequencing: flag update and line/duty result.
`timescale 1ns / 1ps

module hds_step (
    input  hds_pkg::t_in_item     i_item,
    input  hds_pkg::t_motor_flags i_cur,
    input  logic [14:0]           i_deadband,
    input  logic [15:0]           i_off_refresh,
    output logic                  o_in_range,
    output hds_pkg::t_motor_flags o_nxt,
    output hds_pkg::t_out_item    o_result
);

    logic        neg;
    logic [15:0] mag_raw;
    logic [14:0] mag;
    logic        en;
    logic        fet;
    logic [14:0] duty1;
    logic [14:0] duty2;
    logic [15:0] period;
    hds_pkg::t_motor_flags nxt;

    assign neg     = i_item.drive_command[15];
    assign mag_raw = neg ? 16'(-i_item.drive_command) : 16'(i_item.drive_command);
    assign mag     = mag_raw[15] ? hds_pkg::DUTY_MAX : mag_raw[14:0];
    assign en      = i_item.enable_request;

    assign o_in_range = (32'(i_item.motor_index) < hds_pkg::NUM_MOTORS);

    always_comb begin
        nxt    = i_cur;
        fet    = 1'b0;
        duty1  = '0;
        duty2  = '0;
        period = i_off_refresh;

        if (!en && i_cur.enabled) begin
            nxt.enabled   = 1'b0;
            nxt.first_cmd = 1'b1;
            fet           = 1'b1;
        end else if (en) begin
            nxt.enabled = 1'b1;
        end

        if (en) begin
            if (mag < i_deadband) begin
                nxt.first_cmd = 1'b1;
            end else if (neg) begin
                if (i_cur.direction) begin
                    nxt.first_cmd = 1'b1;
                end else begin
                    nxt.first_cmd = 1'b0;
                    duty1         = mag;
                    period        = i_item.refresh_ms;
                end
                nxt.direction = 1'b0;
            end else begin
                if (!i_cur.direction) begin
                    nxt.first_cmd = 1'b1;
                end else begin
                    nxt.first_cmd = 1'b0;
                    duty2         = mag;
                    period        = i_item.refresh_ms;
                end
                nxt.direction = 1'b1;
            end
        end
    end

    assign o_nxt = nxt;

    always_comb begin
        o_result            = '0;
        o_result.motor_echo = i_item.motor_index;
        o_result.period_ms  = i_off_refresh;
        if (o_in_range) begin
            o_result.enable_line     = nxt.enabled;
            o_result.low_side_one    = !nxt.first_cmd && nxt.direction;
            o_result.low_side_two    = !nxt.first_cmd && !nxt.direction;
            o_result.high_one_duty   = duty1;
            o_result.high_two_duty   = duty2;
            o_result.period_ms       = period;
            o_result.fet_delay_taken = fet;
        end
    end

endmodule

// ===== design/hbridge_direction_sequencer.sv =====
// Top level of the H-bridge direction sequencer: config, pipeline registers, flag bank.
//
//   channel   signals                                      moves
//   in        i_in_valid / o_in_stall / i_in_data          one motor command
//   out       o_out_valid / i_out_stall / o_out_data       one line/duty result
//   cfg       i_cfg_we / i_cfg_index / i_cfg_wdata         register write
//
// Each accepted transaction passes through the input register r_in and then the result register r_out;
// one transaction per cycle sustained while the output is not stalled.
// Per-motor flags are read and written in the input-register stage, so
// back-to-back commands to the same motor see each other's update.
// Synchronous active-low reset clears flags (first-command set) and config to defaults.
// Output stall backs up into o_in_stall only when both stages are full.
`timescale 1ns / 1ps

module hbridge_direction_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  hds_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output hds_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hds_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic [14:0]           r_deadband;
    logic [15:0]           r_off_refresh;
    logic                  r_in_valid;
    hds_pkg::t_in_item     r_in;
    logic                  r_out_valid;
    hds_pkg::t_out_item    r_out;

    logic                  out_ready;
    logic                  advance;
    logic                  in_range;
    hds_pkg::t_motor_flags cur_flags;
    hds_pkg::t_motor_flags nxt_flags;
    hds_pkg::t_out_item    result;
    hds_pkg::t_motor_sel   sel;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign sel        = hds_pkg::t_motor_sel'(r_in.motor_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband    <= hds_pkg::DEADBAND_RST;
            r_off_refresh <= hds_pkg::OFF_REFRESH_RST;
        end else if (i_cfg_we) begin
            unique case (hds_pkg::t_cfg_reg'(i_cfg_index))
                hds_pkg::CFG_DEADBAND:    r_deadband    <= i_cfg_wdata[14:0];
                hds_pkg::CFG_OFF_REFRESH: r_off_refresh <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    hds_flag_bank u_flags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_sel   (sel),
        .o_rd_flags (cur_flags),
        .i_wr_en    (advance && in_range),
        .i_wr_sel   (sel),
        .i_wr_flags (nxt_flags)
    );

    hds_step u_step (
        .i_item        (r_in),
        .i_cur         (cur_flags),
        .i_deadband    (r_deadband),
        .i_off_refresh (r_off_refresh),
        .o_in_range    (in_range),
        .o_nxt         (nxt_flags),
        .o_result      (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/hds_checker.sv =====
// Port-level checker for the H-bridge direction sequencer, bound to the top level.
`timescale 1ns / 1ps

module hds_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input hds_pkg::t_out_item i_out_data
);

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    a_low_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.low_side_one && i_out_data.low_side_two))
        else $error("both low sides raised");

    a_high_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.high_one_duty == '0 || i_out_data.high_two_duty == '0))
        else $error("both high sides driven");

    a_fet_drops_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.fet_delay_taken |->
            !i_out_data.enable_line && !i_out_data.low_side_one && !i_out_data.low_side_two)
        else $error("disable sequence left a line raised");

endmodule

bind hbridge_direction_sequencer hds_checker u_hds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
